// File: design/spm_pkg.sv
`default_nettype none

package spm_pkg;

   // Operand storage
   localparam int MaxTerms = 8;
   localparam int CoefW    = 8;
   localparam int ExpoW    = 7;
   localparam int TermW    = CoefW + ExpoW;

   // Product and accumulation
   localparam int ProdW    = 2 * CoefW;
   localparam int AccW     = 22;
   localparam int OutCoefW = 21;
   localparam int OutExpoW = 8;

   // Exponent bins: exponent sums -128..126, biased by 128
   localparam int BinCount = 255;
   localparam int BinIdxW  = 8;

   typedef enum logic [1:0] {
      MODE_LOAD_A = 2'd0,
      MODE_LOAD_B = 2'd1,
      MODE_MULT   = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef struct packed {
      logic signed [CoefW-1:0] coef;
      logic signed [ExpoW-1:0] expo;
   } term_type;

   // Accumulator access from the multiply-accumulate pipeline
   typedef struct packed {
      logic                   rd_en;
      logic [BinIdxW-1:0]     rd_idx;
      logic                   wr_en;
      logic [BinIdxW-1:0]     wr_idx;
      logic signed [AccW-1:0] wr_data;
      logic [BinIdxW-1:0]     look_idx;
      logic                   busy;
   } mac_port_type;

   // Clamp an accumulated sum to the result coefficient range
   function automatic logic signed [OutCoefW-1:0] sat_coef(input logic signed [AccW-1:0] v);
      logic signed [OutCoefW-1:0] r;
      if (v[AccW-1] != v[OutCoefW-1]) begin
         r = v[AccW-1] ? {1'b1, {(OutCoefW-1){1'b0}}} : {1'b0, {(OutCoefW-1){1'b1}}};
      end else begin
         r = v[OutCoefW-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: design/sparse_polynomial_multiply.sv
`default_nettype none

// Sparse polynomial multiplier. Load items (mode 0 into operand A, mode 1
// into operand B) store one term each; a load into a full operand is
// dropped and raises the overflow flag reported with the next multiply. A
// multiply item (mode 2) forms all A x B term products, one pair per cycle
// through a multiply-accumulate pipeline that reads, adds and writes back
// an exponent-bin accumulator RAM (back-to-back hits on a bin are
// forwarded), then scans the 255 bins one per cycle, each occupied bin also
// passing through a read state that can wait for the output to be free, and
// emits one result per occupied bin in ascending exponent order, the final
// one marked last_term. Both operands and the overflow flag are cleared
// after the multiply. The pipeline and the bin scan share a single
// accumulator RAM. If either operand is empty, a single result with
// empty_result set is emitted. Bin occupancy lives in flip-flops cleared
// all at once, so no clearing pass runs after reset. Mode 3 is ignored.
module sparse_polynomial_multiply #(
   parameter int MAX_TERMS = spm_pkg::MaxTerms
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [1:0]                           req_mode,
   input  wire logic signed [spm_pkg::CoefW-1:0]     req_coefficient,
   input  wire logic signed [spm_pkg::ExpoW-1:0]     req_exponent,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [spm_pkg::OutCoefW-1:0]       rsp_product_coefficient,
   output logic signed [spm_pkg::OutExpoW-1:0]       rsp_product_exponent,
   output logic                                      rsp_last_term,
   output logic                                      rsp_empty_result,
   output logic                                      rsp_overflow
);

   import spm_pkg::*;

   localparam int AddrW  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CountW = $clog2(MAX_TERMS + 1);
   localparam logic [BinIdxW-1:0] BinLast = BinIdxW'(BinCount - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAIRS,
      ST_DRAIN,
      ST_SCAN,
      ST_SCAN_DATA,
      ST_FINISH,
      ST_EMPTY
   } state_type;

   state_type                  state_ff, state_in;
   logic [CountW-1:0]          a_count_ff, a_count_in;
   logic [CountW-1:0]          b_count_ff, b_count_in;
   logic                       dropped_ff, dropped_in;
   logic [AddrW-1:0]           i_ff, i_in;
   logic [AddrW-1:0]           j_ff, j_in;
   logic                       pair_valid_ff, pair_valid_in;
   logic [BinIdxW-1:0]         sc_ff, sc_in;
   logic [BinCount-1:0]        present_ff, present_in;
   logic                       hold_valid_ff, hold_valid_in;
   logic signed [AccW-1:0]     hold_coef_ff, hold_coef_in;
   logic signed [OutExpoW-1:0] hold_expo_ff, hold_expo_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [OutCoefW-1:0] rsp_coef_ff, rsp_coef_in;
   logic signed [OutExpoW-1:0] rsp_expo_ff, rsp_expo_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       rsp_empty_ff, rsp_empty_in;
   logic                       rsp_ovf_ff, rsp_ovf_in;

   logic                       accept;
   logic                       out_free;
   logic                       a_wr_en, b_wr_en;
   logic                       term_rd_en;
   logic                       scan_rd;
   logic                       do_clear;
   logic                       last_i, last_j;
   logic [TermW-1:0]           a_rd_data, b_rd_data;
   logic [AccW-1:0]            acc_rd_raw;
   logic [BinIdxW-1:0]         acc_rd_addr;
   mac_port_type               mac;

   // Operand term stores
   spm_ram #(.Width(TermW), .Depth(MAX_TERMS)) u_a_ram (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (a_count_ff[AddrW-1:0]),
      .wr_data ({req_coefficient, req_exponent}),
      .rd_en   (term_rd_en),
      .rd_addr (i_ff),
      .rd_data (a_rd_data)
   );

   spm_ram #(.Width(TermW), .Depth(MAX_TERMS)) u_b_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_count_ff[AddrW-1:0]),
      .wr_data ({req_coefficient, req_exponent}),
      .rd_en   (term_rd_en),
      .rd_addr (j_ff),
      .rd_data (b_rd_data)
   );

   // Exponent-bin accumulators, shared by the pipeline and the scan
   assign acc_rd_addr = scan_rd ? sc_ff : mac.rd_idx;

   spm_ram #(.Width(AccW), .Depth(BinCount)) u_acc_ram (
      .clock   (clock),
      .wr_en   (mac.wr_en),
      .wr_addr (mac.wr_idx),
      .wr_data (mac.wr_data),
      .rd_en   (mac.rd_en | scan_rd),
      .rd_addr (acc_rd_addr),
      .rd_data (acc_rd_raw)
   );

   spm_mac u_mac (
      .clock        (clock),
      .reset        (reset),
      .pair_valid   (pair_valid_ff),
      .a_term       (term_type'(a_rd_data)),
      .b_term       (term_type'(b_rd_data)),
      .acc_rd_data  (acc_rd_raw),
      .look_present (present_ff[mac.look_idx]),
      .clear        (do_clear),
      .port         (mac)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign last_i    = (CountW'(i_ff) + CountW'(1)) == a_count_ff;
   assign last_j    = (CountW'(j_ff) + CountW'(1)) == b_count_ff;

   // Sequence loads, the pair walk, the bin scan and result emission
   always_comb begin
      state_in      = state_ff;
      a_count_in    = a_count_ff;
      b_count_in    = b_count_ff;
      dropped_in    = dropped_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      pair_valid_in = 1'b0;
      sc_in         = sc_ff;
      present_in    = present_ff;
      hold_valid_in = hold_valid_ff;
      hold_coef_in  = hold_coef_ff;
      hold_expo_in  = hold_expo_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_coef_in   = rsp_coef_ff;
      rsp_expo_in   = rsp_expo_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      a_wr_en       = 1'b0;
      b_wr_en       = 1'b0;
      term_rd_en    = 1'b0;
      scan_rd       = 1'b0;
      do_clear      = 1'b0;

      // Mark bins touched by the pipeline
      if (mac.wr_en) begin
         present_in[mac.wr_idx] = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  MODE_LOAD_A: begin
                     if (a_count_ff == CountW'(MAX_TERMS)) begin
                        dropped_in = 1'b1;
                     end else begin
                        a_wr_en    = 1'b1;
                        a_count_in = a_count_ff + CountW'(1);
                     end
                  end
                  MODE_LOAD_B: begin
                     if (b_count_ff == CountW'(MAX_TERMS)) begin
                        dropped_in = 1'b1;
                     end else begin
                        b_wr_en    = 1'b1;
                        b_count_in = b_count_ff + CountW'(1);
                     end
                  end
                  MODE_MULT: begin
                     if ((a_count_ff == '0) || (b_count_ff == '0)) begin
                        state_in = ST_EMPTY;
                     end else begin
                        i_in     = '0;
                        j_in     = '0;
                        state_in = ST_PAIRS;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PAIRS: begin
            // Issue one term pair per cycle
            term_rd_en    = 1'b1;
            pair_valid_in = 1'b1;
            if (last_j) begin
               j_in = '0;
               if (last_i) begin
                  state_in = ST_DRAIN;
               end else begin
                  i_in = i_ff + AddrW'(1);
               end
            end else begin
               j_in = j_ff + AddrW'(1);
            end
         end
         ST_DRAIN: begin
            if (!pair_valid_ff && !mac.busy) begin
               sc_in    = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (present_ff[sc_ff]) begin
               scan_rd  = 1'b1;
               state_in = ST_SCAN_DATA;
            end else if (sc_ff == BinLast) begin
               state_in = ST_FINISH;
            end else begin
               sc_in = sc_ff + BinIdxW'(1);
            end
         end
         ST_SCAN_DATA: begin
            // Keep one bin in hand so the final result can be marked last
            if (!hold_valid_ff || out_free) begin
               if (hold_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_coef_in  = sat_coef(hold_coef_ff);
                  rsp_expo_in  = hold_expo_ff;
                  rsp_last_in  = 1'b0;
                  rsp_empty_in = 1'b0;
                  rsp_ovf_in   = dropped_ff;
               end
               hold_valid_in = 1'b1;
               hold_coef_in  = acc_rd_raw;
               hold_expo_in  = {~sc_ff[BinIdxW-1], sc_ff[BinIdxW-2:0]};
               if (sc_ff == BinLast) begin
                  state_in = ST_FINISH;
               end else begin
                  sc_in    = sc_ff + BinIdxW'(1);
                  state_in = ST_SCAN;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_coef_in   = sat_coef(hold_coef_ff);
               rsp_expo_in   = hold_expo_ff;
               rsp_last_in   = 1'b1;
               rsp_empty_in  = 1'b0;
               rsp_ovf_in    = dropped_ff;
               do_clear      = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_coef_in  = '0;
               rsp_expo_in  = '0;
               rsp_last_in  = 1'b1;
               rsp_empty_in = 1'b1;
               rsp_ovf_in   = dropped_ff;
               do_clear     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Drop operands, flag and bins after a multiply
      if (do_clear) begin
         a_count_in    = '0;
         b_count_in    = '0;
         dropped_in    = 1'b0;
         present_in    = '0;
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         a_count_ff    <= '0;
         b_count_ff    <= '0;
         dropped_ff    <= 1'b0;
         pair_valid_ff <= 1'b0;
         present_ff    <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         a_count_ff    <= a_count_in;
         b_count_ff    <= b_count_in;
         dropped_ff    <= dropped_in;
         pair_valid_ff <= pair_valid_in;
         present_ff    <= present_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      i_ff         <= i_in;
      j_ff         <= j_in;
      sc_ff        <= sc_in;
      hold_coef_ff <= hold_coef_in;
      hold_expo_ff <= hold_expo_in;
      rsp_coef_ff  <= rsp_coef_in;
      rsp_expo_ff  <= rsp_expo_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_product_coefficient = rsp_coef_ff;
   assign rsp_product_exponent    = rsp_expo_ff;
   assign rsp_last_term           = rsp_last_ff;
   assign rsp_empty_result        = rsp_empty_ff;
   assign rsp_overflow            = rsp_ovf_ff;

endmodule

`default_nettype wire

// File: design/spm_ram.sv
`default_nettype none

module spm_ram #(
   parameter int Width = 8,
   parameter int Depth = 8
) (
   input  wire logic                                         clock,
   input  wire logic                                         wr_en,
   input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  wire logic [Width-1:0]                             wr_data,
   input  wire logic                                         rd_en,
   input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic      [Width-1:0]                             rd_data
);

   logic [Width-1:0] mem [Depth];

   // Write port and registered read port; read during write returns old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: design/spm_mac.sv
`default_nettype none

module spm_mac (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          pair_valid,
   input  wire spm_pkg::term_type             a_term,
   input  wire spm_pkg::term_type             b_term,
   input  wire logic signed [spm_pkg::AccW-1:0] acc_rd_data,
   input  wire logic                          look_present,
   input  wire logic                          clear,
   output spm_pkg::mac_port_type              port
);

   import spm_pkg::*;

   logic                      s2_valid_ff, s2_valid_in;
   logic [BinIdxW-1:0]        s2_idx_ff, s2_idx_in;
   logic signed [ProdW-1:0]   s2_prod_ff, s2_prod_in;
   logic                      s3_valid_ff;
   logic [BinIdxW-1:0]        s3_idx_ff;
   logic signed [ProdW-1:0]   s3_prod_ff;
   logic                      wr_valid_ff, wr_valid_in;
   logic [BinIdxW-1:0]        wr_idx_ff;
   logic signed [AccW-1:0]    wr_val_ff;
   logic signed [OutExpoW-1:0] expo_sum;
   logic signed [AccW-1:0]    base;
   logic signed [AccW-1:0]    sum;

   // Multiply coefficients, add exponents and bias into a bin index
   always_comb begin
      expo_sum    = {a_term.expo[ExpoW-1], a_term.expo} + {b_term.expo[ExpoW-1], b_term.expo};
      s2_prod_in  = a_term.coef * b_term.coef;
      s2_idx_in   = {~expo_sum[OutExpoW-1], expo_sum[OutExpoW-2:0]};
      s2_valid_in = pair_valid;
   end

   // Merge: forward the last write, else memory if the bin is live, else zero
   always_comb begin
      if (wr_valid_ff && (wr_idx_ff == s3_idx_ff)) begin
         base = wr_val_ff;
      end else if (look_present) begin
         base = acc_rd_data;
      end else begin
         base = '0;
      end
      sum         = base + {{(AccW-ProdW){s3_prod_ff[ProdW-1]}}, s3_prod_ff};
      wr_valid_in = clear ? 1'b0 : (wr_valid_ff | s3_valid_ff);
   end

   always_comb begin
      port.rd_en    = s2_valid_ff;
      port.rd_idx   = s2_idx_ff;
      port.wr_en    = s3_valid_ff;
      port.wr_idx   = s3_idx_ff;
      port.wr_data  = sum;
      port.look_idx = s3_idx_ff;
      port.busy     = s2_valid_ff | s3_valid_ff;
   end

   // Advance the pipeline and hold the most recent write for forwarding
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         wr_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s2_valid_ff;
         wr_valid_ff <= wr_valid_in;
      end
      s2_idx_ff  <= s2_idx_in;
      s2_prod_ff <= s2_prod_in;
      s3_idx_ff  <= s2_idx_ff;
      s3_prod_ff <= s2_prod_ff;
      if (s3_valid_ff) begin
         wr_idx_ff <= s3_idx_ff;
         wr_val_ff <= sum;
      end
   end

endmodule

`default_nettype wire
